// ===== sv/wbps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern search block.
// ----------------------------------------------------------------------------
package wbps_pkg;

	localparam int PAT_BYTES = 16;   // pattern register space, bytes
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 5;   // four 64-bit registers at 8-byte spacing
	localparam int COUNT_W = 32;
	localparam int LEN_W = 5;
	localparam int MASK_W = 16;

	typedef enum logic [1:0] {
		REG_PAT_LO = 2'd0,
		REG_PAT_HI = 2'd1,
		REG_CARE   = 2'd2,
		REG_LEN    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic               match_found;
		logic [COUNT_W-1:0] match_offset;
		logic               scan_done;
		logic [COUNT_W-1:0] total_matches;
	} result_item_t;

endpackage

`default_nettype wire

// ===== sv/wbps_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbps stream interfaces
// Valid/ready channels for scanned bytes and for search results.
// ----------------------------------------------------------------------------
interface wbps_byte_if;
	logic                valid;
	logic                ready;
	wbps_pkg::byte_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface wbps_result_if;
	logic                  valid;
	logic                  ready;
	wbps_pkg::result_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== sv/wildcard_byte_pattern_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: input stage, then result stage; a stalled result channel holds the byte in the input stage.
// Throughput: one byte per cycle while the result channel is not stalled; the window compare
// is fully parallel in the result stage.
// Bytes that end no match and are not last produce no result transfer.
// Reset (arst_n low, asynchronous): window and counters clear, pattern 0, care mask all ones,
// length 1. Window and counters also clear after the byte marked last.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search
// Masked byte pattern search over a byte stream, APB register port.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search #(
	parameter int MAX_PATTERN_BYTES = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	wbps_byte_if.sink                           bytes,
	wbps_result_if.source                       results,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [wbps_pkg::CFG_ADDR_W-1:0]     paddr,
	input  wire  [wbps_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [wbps_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int LEN_LIMIT = (MAX_PATTERN_BYTES < wbps_pkg::PAT_BYTES) ?
		MAX_PATTERN_BYTES : wbps_pkg::PAT_BYTES;
	localparam int IDX_W = (LEN_LIMIT > 1) ? $clog2(LEN_LIMIT) : 1;
	localparam int CW = wbps_pkg::COUNT_W;
	localparam int LW = wbps_pkg::LEN_W;

	// configuration
	logic [63:0]                 pat_lo_q, pat_hi_q;
	logic [wbps_pkg::MASK_W-1:0] care_q;
	logic [LW-1:0]               len_q;
	wbps_pkg::reg_idx_t          reg_sel;
	logic                        cfg_wr;

	assign reg_sel = wbps_pkg::reg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			care_q   <= '1;
			len_q    <= LW'(1);
		end else if (cfg_wr) begin
			case (reg_sel)
				wbps_pkg::REG_PAT_LO: pat_lo_q <= pwdata;
				wbps_pkg::REG_PAT_HI: pat_hi_q <= pwdata;
				wbps_pkg::REG_CARE:   care_q   <= pwdata[wbps_pkg::MASK_W-1:0];
				wbps_pkg::REG_LEN:    len_q    <= pwdata[LW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			wbps_pkg::REG_PAT_LO: prdata = pat_lo_q;
			wbps_pkg::REG_PAT_HI: prdata = pat_hi_q;
			wbps_pkg::REG_CARE:   prdata = 64'(care_q);
			wbps_pkg::REG_LEN:    prdata = 64'(len_q);
			default:              prdata = '0;
		endcase
	end

	// effective pattern length: zero reads as one, clipped to the window
	logic [LW-1:0] eff_len;
	always_comb begin
		eff_len = len_q;
		if (len_q == '0)
			eff_len = LW'(1);
		if (len_q > LW'(LEN_LIMIT))
			eff_len = LW'(LEN_LIMIT);
	end

	// input stage
	logic                 valid_s1;
	wbps_pkg::byte_item_t item_s1;
	logic                 out_free;
	logic                 adv;

	assign out_free    = !results.valid || results.ready;
	assign adv         = valid_s1 && out_free;
	assign bytes.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid)
			item_s1 <= bytes.item;
	end

	// section state
	logic [7:0]    window_q [MAX_PATTERN_BYTES];
	logic [CW-1:0] seen_q, matches_q;

	// window including the byte in the input stage, entry 0 newest
	logic [7:0] cmp_win [LEN_LIMIT];
	always_comb begin
		for (int k = 0; k < LEN_LIMIT; k++) begin
			if (k == 0)
				cmp_win[k] = item_s1.data_byte;
			else
				cmp_win[k] = window_q[k-1];
		end
	end

	logic [127:0] pat_all;
	logic         cmp_ok;
	assign pat_all = {pat_hi_q, pat_lo_q};

	// pattern byte j against the byte eff_len-1-j places back
	always_comb begin
		logic [LW-1:0] pos;
		pos    = '0;
		cmp_ok = 1'b1;
		for (int j = 0; j < LEN_LIMIT; j++) begin
			pos = eff_len - LW'(j) - LW'(1);
			if ((LW'(j) < eff_len) && care_q[j] &&
			    (pat_all[8*j +: 8] != cmp_win[pos[IDX_W-1:0]]))
				cmp_ok = 1'b0;
		end
	end

	logic [CW-1:0] seen_inc, matches_inc, offset;
	logic          hit, emit;

	assign seen_inc    = (seen_q == '1) ? seen_q : seen_q + CW'(1);
	assign hit         = cmp_ok && (seen_inc >= CW'(eff_len));
	assign offset      = hit ? seen_inc - CW'(eff_len) : '0;
	assign matches_inc = (hit && (matches_q != '1)) ? matches_q + CW'(1) : matches_q;
	assign emit        = hit || item_s1.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			matches_q <= '0;
			for (int k = 0; k < MAX_PATTERN_BYTES; k++)
				window_q[k] <= '0;
		end else if (adv) begin
			if (item_s1.last_byte) begin
				seen_q    <= '0;
				matches_q <= '0;
				for (int k = 0; k < MAX_PATTERN_BYTES; k++)
					window_q[k] <= '0;
			end else begin
				seen_q    <= seen_inc;
				matches_q <= matches_inc;
				window_q[0] <= item_s1.data_byte;
				for (int k = 1; k < MAX_PATTERN_BYTES; k++)
					window_q[k] <= window_q[k-1];
			end
		end
	end

	// result register
	wbps_pkg::result_item_t res_s2;
	logic                   res_valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (out_free) begin
			res_valid_s2 <= adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_s2.match_found   <= hit;
			res_s2.match_offset  <= offset;
			res_s2.scan_done     <= item_s1.last_byte;
			res_s2.total_matches <= matches_inc;
		end
	end

	assign results.valid = res_valid_s2;
	assign results.item  = res_s2;

endmodule

`default_nettype wire

// ===== sv/wbps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks on the result channel of the pattern search block.
// ----------------------------------------------------------------------------
module wbps_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         res_valid,
	input wire                         res_ready,
	input wire wbps_pkg::result_item_t res_item
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// only a match or the section end produces a result
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.match_found || res_item.scan_done)
		else $error("result with neither match nor end marker");

	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.match_found |-> res_item.match_offset == '0)
		else $error("offset nonzero without match");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.match_found |-> res_item.total_matches != '0)
		else $error("match reported with zero count");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_item  (results.item)
);

`default_nettype wire
